// File: rtl/core/mexp_pkg.sv
// Shared word width, register indexes and related types for the modular exponentiation block.
package mexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int INDEX_BITS = 2;
  localparam int CNT_BITS = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [INDEX_BITS-1:0] reg_index_t;

  localparam reg_index_t REG_MODULUS = INDEX_BITS'(0);
  localparam reg_index_t REG_EXPONENT = INDEX_BITS'(1);

endpackage

// File: rtl/core/mexp_if.sv
// Valid/ready channel interfaces for base items, power results and register writes.
interface mexp_in_if;
  import mexp_pkg::*;
  logic valid;
  logic ready;
  word_t base;
  modport source(output valid, output base, input ready);
  modport sink(input valid, input base, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;
  logic valid;
  logic ready;
  word_t power;
  modport source(output valid, output power, input ready);
  modport sink(input valid, input power, output ready);
endinterface

interface mexp_cfg_if;
  import mexp_pkg::*;
  logic valid;
  logic ready;
  reg_index_t index;
  word_t data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/modular_exponentiation_top.sv
// Right-to-left square-and-multiply modular exponentiation with one shift-add modular multiplier.
//
// Usage: write the modulus (index 0) and the exponent (index 1) through the cfg channel,
// which is always ready and takes one write per cycle. Each transfer on the item channel
// carries a base; one transfer on the result channel later returns base^exponent mod modulus.
// Writes to other indexes are dropped, and a modulus of zero returns zero without any product.
// Each modular product runs through the shared multiplier, one multiplier bit per cycle.
// An item needs one product to reduce the base, one square per exponent bit and one
// extra product per set exponent bit.
// The item channel is ready only while the sequencer is idle.
// The result sits in an output register; a new item is taken while it waits. If the
// receiver still stalls when the next result is finished, the sequencer holds in its
// final state until the register frees up.
// Reset is synchronous: the modulus returns to 1, the exponent to 0, the sequencer goes
// idle and any pending result is dropped.
module modular_exponentiation_top (
  input logic clk,
  input logic rst,
  mexp_cfg_if.sink cfg,
  mexp_in_if.sink item,
  mexp_out_if.source result
);
  import mexp_pkg::*;

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_MUL    = 5'b00100,
    S_SQUARE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  word_t modulus, exponent;
  word_t mod_op;
  word_t acc, sq, acc_next, sq_next;
  word_t e_sh;
  logic [CNT_BITS-1:0] ebit;
  word_t mul_a, mul_b, mul_acc;
  logic [CNT_BITS-1:0] mul_cnt;
  word_t power;
  logic out_valid;

  word_t partial, step_res;
  logic [WORD_BITS+1:0] step_sum, step_sub1, step_sub2;
  logic mul_busy, mul_done;
  word_t one_mod;

  assign cfg.ready = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.power = power;

  // 1 mod m, used both as the starting accumulator and as the factor that reduces the base.
  assign one_mod = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

  // One multiplier bit per cycle: 2*acc + bit*a lies below 3m, so subtract m or 2m.
  assign partial = mul_b[WORD_BITS-1] ? mul_a : '0;
  assign step_sum = {1'b0, mul_acc, 1'b0} + {2'b00, partial};
  assign step_sub1 = step_sum - {2'b00, mod_op};
  assign step_sub2 = step_sum - {1'b0, mod_op, 1'b0};

  always_comb begin
    if (!step_sub2[WORD_BITS+1]) begin
      step_res = step_sub2[WORD_BITS-1:0];
    end else if (!step_sub1[WORD_BITS+1]) begin
      step_res = step_sub1[WORD_BITS-1:0];
    end else begin
      step_res = step_sum[WORD_BITS-1:0];
    end
  end

  assign mul_busy = (state == S_REDUCE) || (state == S_MUL) || (state == S_SQUARE);
  assign mul_done = mul_busy && (mul_cnt == CNT_LAST);

  // Where the sequencer goes when the current product finishes.
  always_comb begin
    acc_next = acc;
    sq_next = sq;
    state_next = state;
    case (state)
      S_REDUCE: begin
        sq_next = step_res;
        state_next = e_sh[0] ? S_MUL : S_SQUARE;
      end
      S_MUL: begin
        acc_next = step_res;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        sq_next = step_res;
        if (ebit == CNT_LAST) begin
          state_next = S_DONE;
        end else begin
          state_next = e_sh[1] ? S_MUL : S_SQUARE;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_BITS'(1);
      exponent <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MODULUS: modulus <= cfg.data;
        REG_EXPONENT: exponent <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A finished result refills the register in the same cycle as the previous transfer.
      if ((state == S_DONE) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid && item.ready) begin
            state <= (modulus == '0) ? S_DONE : S_REDUCE;
          end
        end
        S_REDUCE, S_MUL, S_SQUARE: begin
          if (mul_done) begin
            state <= state_next;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers carry no reset; the sequencer decides when they are meaningful.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          mod_op <= modulus;
          acc <= (modulus == '0) ? '0 : one_mod;
          mul_a <= one_mod;
          mul_b <= item.base;
          mul_acc <= '0;
          mul_cnt <= '0;
          e_sh <= exponent;
          ebit <= '0;
        end
      end
      S_REDUCE, S_MUL, S_SQUARE: begin
        if (mul_done) begin
          acc <= acc_next;
          sq <= sq_next;
          mul_a <= (state_next == S_MUL) ? acc_next : sq_next;
          mul_b <= sq_next;
          mul_acc <= '0;
          mul_cnt <= '0;
          if (state == S_SQUARE) begin
            e_sh <= {1'b0, e_sh[WORD_BITS-1:1]};
            ebit <= ebit + CNT_BITS'(1);
          end
        end else begin
          mul_acc <= step_res;
          mul_b <= {mul_b[WORD_BITS-2:0], 1'b0};
          mul_cnt <= mul_cnt + CNT_BITS'(1);
        end
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          power <= acc;
        end
      end
      default: begin
      end
    endcase
  end

  // The partial product must stay fully reduced throughout a multiplication.
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    mul_busy |-> (mul_acc < mod_op))
    else $error("partial product not below modulus");

  // Operands handed to the multiplier after the base reduction are residues.
  a_operand_reduced: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MUL) || (state == S_SQUARE)) |->
      (mul_a < mod_op) && (mul_b < mod_op || mul_cnt != '0))
    else $error("multiplier operand not below modulus");

  // The bit counter advances by one per cycle inside a product.
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (mul_busy && mul_cnt != '0) |-> (mul_cnt == $past(mul_cnt) + CNT_BITS'(1)))
    else $error("multiplier bit counter skipped");

  // A result appears only from the final sequencer state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the final state");

  // An accepted item always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state != S_IDLE))
    else $error("accepted item did not start");

endmodule
